### design/motor_command_session_watchdog_core_assert.svh
// Assertion macros shared by the watchdog checker.
`ifndef MOTOR_COMMAND_SESSION_WATCHDOG_CORE_ASSERT_SVH
`define MOTOR_COMMAND_SESSION_WATCHDOG_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define MCSW_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define MCSW_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

### design/mcsw_pkg.sv
// Types, constants and helper functions of the motor command session watchdog.
package mcsw_pkg;

   localparam int TIME_W    = 48;
   localparam int VEL_W     = 32;
   localparam int CNT_W     = 32;
   localparam int CFG_W     = 32;
   localparam int MASK_W    = 4;
   localparam int SLOT_IN_W = 8;
   localparam int SLOT_W    = 2;
   localparam int CSR_IDX_W = 8;

   // actuator slots present
   localparam int SLOT_COUNT = 4;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   localparam logic [CFG_W-1:0]  STOP_HOLD_RST   = 32'd500000;
   localparam logic [CFG_W-1:0]  SEND_PERIOD_RST = 32'd20000;
   localparam logic [CFG_W-1:0]  MAX_AGE_RST     = 32'd200000;
   localparam logic [MASK_W-1:0] ENABLE_MASK_RST = 4'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STOP_HOLD   = 8'd0,
      CSR_SEND_PERIOD = 8'd1,
      CSR_MAX_AGE     = 8'd2,
      CSR_ENABLE_MASK = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0]  stop_hold_us;
      logic [CFG_W-1:0]  send_period_us;
      logic [CFG_W-1:0]  command_max_age_us;
      logic [MASK_W-1:0] actuator_enable_mask;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]       now_us;
      logic [TIME_W-1:0]       cmd_time_us;
      logic                    cmd_transmit_on;
      logic [SLOT_IN_W-1:0]    cmd_slot;
      logic                    cmd_motion_ok;
      logic signed [VEL_W-1:0] cmd_velocity;
   } cmd_item_type;

   typedef struct packed {
      logic                    session_on;
      logic                    stopping_now;
      logic [SLOT_W-1:0]       drive_slot;
      logic signed [VEL_W-1:0] drive_velocity;
      logic                    send_request;
      logic [CNT_W-1:0]        sends_so_far;
   } result_type;

   // time plus offset, clamped at the largest representable time
   function automatic logic [TIME_W-1:0] time_add_sat(input logic [TIME_W-1:0] t,
                                                     input logic [CFG_W-1:0]  d);
      logic [TIME_W:0] sum;
      sum = {1'b0, t} + {{(TIME_W+1-CFG_W){1'b0}}, d};
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

   // slots past the slot count or past the mask width are disabled
   function automatic logic slot_enabled(input logic [MASK_W-1:0]    mask,
                                         input logic [SLOT_IN_W-1:0] slot);
      logic in_range;
      in_range = (slot < SLOT_IN_W'(SLOT_COUNT)) && (slot < SLOT_IN_W'(MASK_W));
      return in_range && mask[slot[SLOT_W-1:0]];
   endfunction

endpackage

### design/motor_command_session_watchdog_core.sv
// Top level of the motor command session watchdog.
//
// Usage:
//   req_*  : one transaction per control tick (time, latest approved command).
//   rsp_*  : one transaction per tick with session status and send decision.
//   csr_*  : register writes (0 stop hold, 1 send period, 2 max age, 3 enable
//            mask); csr_ready is always high. Write only while idle.
// Timing:
//   rsp_tvalid rises after req acceptance once the tick has left the input
//   register and the decision logic has fed the result register.
//   Throughput is one tick per cycle while rsp_tready stays high; the session
//   state is the only loop and it closes through compare/add logic alone.
// Reset:
//   Synchronous, active high. Clears both pipeline stages, the session state
//   and the send counter; registers return to 500000 / 20000 / 200000 / 0.
// Backpressure:
//   A stalled rsp side holds its transaction stable; the input register still
//   takes one more tick, then req_tready drops until rsp_tready returns.
module motor_command_session_watchdog_core
   import mcsw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // req_tdata fields, low bit up: now_us[47:0], cmd_time_us[95:48],
   // cmd_slot[103:96], cmd_velocity[135:104]
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [135:0]         req_tdata,
   // req_tuser fields, low bit up: cmd_transmit_on[0], cmd_motion_ok[1]
   input  logic [1:0]           req_tuser,
   // rsp_tdata fields, low bit up: drive_slot[1:0], drive_velocity[33:2],
   // sends_so_far[65:34], zero fill [71:66]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,
   // rsp_tuser fields, low bit up: session_on[0], stopping_now[1], send_request[2]
   output logic [2:0]           rsp_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   cfg_type      cfg;
   cmd_item_type req_item;
   cmd_item_type stage_item;
   logic         stage_valid;
   logic         out_space;
   logic         fire;
   result_type   next_result;
   result_type   rsp_result;

   // unpack the request transaction
   always_comb begin
      req_item.now_us          = req_tdata[47:0];
      req_item.cmd_time_us     = req_tdata[95:48];
      req_item.cmd_slot        = req_tdata[103:96];
      req_item.cmd_velocity    = req_tdata[135:104];
      req_item.cmd_transmit_on = req_tuser[0];
      req_item.cmd_motion_ok   = req_tuser[1];
   end

   // held tick moves into the result register when that register has room
   assign fire = stage_valid && out_space;

   mcsw_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mcsw_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (out_space),
      .item_valid (stage_valid),
      .item       (stage_item)
   );

   mcsw_session_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (stage_item),
      .cfg    (cfg),
      .result (next_result)
   );

   mcsw_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (next_result),
      .space      (out_space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   // pack the response transaction
   assign rsp_tdata = {6'd0, rsp_result.sends_so_far, rsp_result.drive_velocity,
                       rsp_result.drive_slot};
   assign rsp_tuser = {rsp_result.send_request, rsp_result.stopping_now,
                       rsp_result.session_on};

endmodule

### design/mcsw_csr_regs.sv
// Configuration register file of the watchdog.
module mcsw_csr_regs
   import mcsw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_STOP_HOLD:   cfg_in.stop_hold_us         = csr_data;
            CSR_SEND_PERIOD: cfg_in.send_period_us       = csr_data;
            CSR_MAX_AGE:     cfg_in.command_max_age_us   = csr_data;
            CSR_ENABLE_MASK: cfg_in.actuator_enable_mask = csr_data[MASK_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_hold_us         <= STOP_HOLD_RST;
         cfg_ff.send_period_us       <= SEND_PERIOD_RST;
         cfg_ff.command_max_age_us   <= MAX_AGE_RST;
         cfg_ff.actuator_enable_mask <= ENABLE_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/mcsw_in_reg.sv
// Input register stage: holds one command tick until the session logic takes it.
module mcsw_in_reg
   import mcsw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  cmd_item_type in_item,
   input  logic         advance,
   output logic         item_valid,
   output cmd_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   cmd_item_type item_ff;

   // room when empty or when the held item leaves this cycle
   assign in_ready   = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

### design/mcsw_session_core.sv
// Session state and per-tick watchdog decision logic.
module mcsw_session_core
   import mcsw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  cmd_item_type item,
   input  cfg_type      cfg,
   output result_type   result
);

   logic                    active_ff,   active_in;
   logic                    stop_ff,     stop_in;
   logic [TIME_W-1:0]       hold_ff,     hold_in;
   logic [TIME_W-1:0]       next_send_ff, next_send_in;
   logic [SLOT_W-1:0]       slot_ff,     slot_in;
   logic signed [VEL_W-1:0] vel_ff,      vel_in;
   logic [CNT_W-1:0]        count_ff,    count_in;

   logic              fresh;
   logic              accept;
   logic              send;
   logic [TIME_W-1:0] age;
   logic [TIME_W-1:0] hold_sum;
   logic [TIME_W-1:0] send_sum;

   assign age      = item.now_us - item.cmd_time_us;
   assign hold_sum = time_add_sat(item.now_us, cfg.stop_hold_us);
   assign send_sum = time_add_sat(item.now_us, cfg.send_period_us);
   assign fresh    = (item.cmd_time_us != '0) && (item.now_us >= item.cmd_time_us) &&
                     (age <= {{(TIME_W-CFG_W){1'b0}}, cfg.command_max_age_us});
   assign accept   = fresh && item.cmd_transmit_on &&
                     slot_enabled(cfg.actuator_enable_mask, item.cmd_slot);

   always_comb begin
      active_in    = active_ff;
      stop_in      = stop_ff;
      hold_in      = hold_ff;
      next_send_in = next_send_ff;
      slot_in      = slot_ff;
      vel_in       = vel_ff;
      count_in     = count_ff;
      send         = 1'b0;

      if (accept) begin
         active_in = 1'b1;
         stop_in   = !item.cmd_motion_ok;
         hold_in   = '0;
         slot_in   = item.cmd_slot[SLOT_W-1:0];
         vel_in    = item.cmd_motion_ok ? item.cmd_velocity : '0;
      end else if (active_ff && !stop_ff) begin
         // commands lapsed: start the zero-velocity hold
         stop_in      = 1'b1;
         hold_in      = hold_sum;
         vel_in       = '0;
         next_send_in = '0;
      end else if (active_ff && stop_ff && (hold_ff == '0)) begin
         hold_in = hold_sum;
      end

      if (active_in && stop_in && (hold_in != '0) && (item.now_us >= hold_in)) begin
         active_in    = 1'b0;
         stop_in      = 1'b0;
         hold_in      = '0;
         next_send_in = '0;
         slot_in      = '0;
         vel_in       = '0;
      end

      if (active_in && ((next_send_in == '0) || (item.now_us >= next_send_in))) begin
         if (slot_enabled(cfg.actuator_enable_mask, {{(SLOT_IN_W-SLOT_W){1'b0}}, slot_in}))
         begin
            send     = 1'b1;
            count_in = count_ff + 1'b1;
         end
         next_send_in = send_sum;
      end
   end

   always_comb begin
      result.session_on     = active_in;
      result.stopping_now   = stop_in;
      result.drive_slot     = slot_in;
      result.drive_velocity = vel_in;
      result.send_request   = send;
      result.sends_so_far   = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         stop_ff      <= 1'b0;
         hold_ff      <= '0;
         next_send_ff <= '0;
         slot_ff      <= '0;
         vel_ff       <= '0;
         count_ff     <= '0;
      end else if (fire) begin
         active_ff    <= active_in;
         stop_ff      <= stop_in;
         hold_ff      <= hold_in;
         next_send_ff <= next_send_in;
         slot_ff      <= slot_in;
         vel_ff       <= vel_in;
         count_ff     <= count_in;
      end
   end

endmodule

### design/mcsw_out_reg.sv
// Result register stage toward the response channel.
module mcsw_out_reg
   import mcsw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign space      = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (space) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

### design/mcsw_checker.sv
// Port-level checker for the watchdog and its bind to the top level.
`include "motor_command_session_watchdog_core_assert.svh"

module mcsw_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   `MCSW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

   `MCSW_ASSERT_SAME(a_stop_in_session, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0] && (rsp_tdata[33:2] == 32'd0), "stopping without session or with velocity")

   `MCSW_ASSERT_SAME(a_idle_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], (rsp_tdata[33:0] == 34'd0) && !rsp_tuser[1] && !rsp_tuser[2], "idle response carries session data")

   `MCSW_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "request stalled while result register empty")

endmodule

bind motor_command_session_watchdog_core mcsw_checker u_mcsw_checker (.*);
